### rtl/qesf_pkg.sv
// ----------------------------------------------------------------------------
// qesf_pkg
// Shared widths, constants and types of the quadrilateral shape function block.
// ----------------------------------------------------------------------------
package qesf_pkg;

  // Fixed-point format of coordinates and results
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned RES_W     = 18;
  localparam int unsigned IDX_W     = 4;

  // Operand and product widths inside the datapath
  localparam int unsigned OP_W   = 18;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned RND_W  = SUM_W - (FRAC_BITS - 1);

  // 1.0 in the working format
  localparam logic signed [OP_W-1:0] ONE = OP_W'(64'd1 << FRAC_BITS);

  // Node count and last node index of each element type
  localparam int unsigned NODES_Q4 = 4;
  localparam int unsigned NODES_Q9 = 9;
  localparam logic [IDX_W-1:0] LAST_Q4 = IDX_W'(NODES_Q4 - 1);
  localparam logic [IDX_W-1:0] LAST_Q9 = IDX_W'(NODES_Q9 - 1);

  // Final right shift applied to a product, relative to FRAC_BITS
  typedef enum logic [1:0] {
    SH_M1,
    SH_0,
    SH_P1,
    SH_P2
  } shift_e;

  // Per-point auxiliary terms, all in the working format
  typedef struct packed {
    logic signed [OP_W-1:0] x;
    logic signed [OP_W-1:0] g;
    logic signed [OP_W-1:0] sm;
    logic signed [OP_W-1:0] sp;
    logic signed [OP_W-1:0] tm;
    logic signed [OP_W-1:0] tp;
    logic signed [OP_W-1:0] um;
    logic signed [OP_W-1:0] up;
    logic signed [OP_W-1:0] vm;
    logic signed [OP_W-1:0] vp;
    logic signed [OP_W-1:0] am;
    logic signed [OP_W-1:0] ap;
    logic signed [OP_W-1:0] bm;
    logic signed [OP_W-1:0] bp;
    logic signed [OP_W-1:0] c;
    logic signed [OP_W-1:0] d;
  } aux_t;

  // One product term in sign-magnitude form
  typedef struct packed {
    logic [OP_W-1:0] p_mag;
    logic [OP_W-1:0] q_mag;
    logic            neg;
    shift_e          sh;
  } factor_t;

  // One node operation handed from the sequencer to the evaluation pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             last;
    factor_t          shape;
    factor_t          dxi;
    factor_t          dgam;
  } node_op_t;

endpackage

### rtl/qesf_if.sv
// ----------------------------------------------------------------------------
// qesf_if
// Valid/ready channels: reference points in, node results out.
// ----------------------------------------------------------------------------
interface qesf_point_if;
  import qesf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_xi;
  logic signed [COORD_W-1:0] coord_gamma;

  modport source (output valid, coord_xi, coord_gamma, input ready);
  modport sink (input valid, coord_xi, coord_gamma, output ready);
endinterface

interface qesf_node_if;
  import qesf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        node_index;
  logic signed [RES_W-1:0] shape_value;
  logic signed [RES_W-1:0] deriv_xi;
  logic signed [RES_W-1:0] deriv_gamma;
  logic                    last_node;

  modport source (output valid, node_index, shape_value, deriv_xi, deriv_gamma, last_node,
                  input ready);
  modport sink (input valid, node_index, shape_value, deriv_xi, deriv_gamma, last_node,
                output ready);
endinterface

### rtl/qesf_aux.sv
// ----------------------------------------------------------------------------
// qesf_aux
// Two-stage front end: raw products of the coordinates, then rounded
// auxiliary terms, held until the node sequencer takes them.
// ----------------------------------------------------------------------------
module qesf_aux (
  input  logic              clk_i,
  input  logic              rst_ni,
  qesf_point_if.sink        point_i,
  output logic              aux_valid_o,
  output qesf_pkg::aux_t    aux_o,
  input  logic              aux_take_i
);
  import qesf_pkg::*;

  // Round a product to the working format, ties away from zero
  function automatic logic signed [OP_W-1:0] round_frac(logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q   = (mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[PROD_W-1] ? OP_W'(-q) : OP_W'(q);
  endfunction

  logic                     a_valid_q, b_valid_q;
  logic                     a_ready, b_ready;
  logic signed [OP_W-1:0]   x_in, g_in, sm_in, sp_in, tm_in, tp_in;
  logic signed [OP_W-1:0]   x_a_q, g_a_q;
  logic signed [PROD_W-1:0] p_xsm_d, p_xsp_d, p_gtm_d, p_gtp_d, p_smsp_d, p_tmtp_d;
  logic signed [PROD_W-1:0] p_xsm_q, p_xsp_q, p_gtm_q, p_gtp_q, p_smsp_q, p_tmtp_q;
  aux_t                     aux_d, aux_q;

  // Handshake: each stage refills as soon as it empties
  assign b_ready       = !b_valid_q || aux_take_i;
  assign a_ready       = !a_valid_q || b_ready;
  assign point_i.ready = a_ready;
  assign aux_valid_o   = b_valid_q;
  assign aux_o         = aux_q;

  // Stage A: offsets and coordinate products
  always_comb begin
    x_in     = {{(OP_W - COORD_W){point_i.coord_xi[COORD_W-1]}}, point_i.coord_xi};
    g_in     = {{(OP_W - COORD_W){point_i.coord_gamma[COORD_W-1]}}, point_i.coord_gamma};
    sm_in    = x_in - ONE;
    sp_in    = x_in + ONE;
    tm_in    = g_in - ONE;
    tp_in    = g_in + ONE;
    p_xsm_d  = x_in * sm_in;
    p_xsp_d  = x_in * sp_in;
    p_gtm_d  = g_in * tm_in;
    p_gtp_d  = g_in * tp_in;
    p_smsp_d = sm_in * sp_in;
    p_tmtp_d = tm_in * tp_in;
  end

  // Stage B: exact linear terms and rounded quadratic terms
  always_comb begin
    aux_d.x  = x_a_q;
    aux_d.g  = g_a_q;
    aux_d.sm = x_a_q - ONE;
    aux_d.sp = x_a_q + ONE;
    aux_d.tm = g_a_q - ONE;
    aux_d.tp = g_a_q + ONE;
    aux_d.um = (x_a_q <<< 1) - ONE;
    aux_d.up = (x_a_q <<< 1) + ONE;
    aux_d.vm = (g_a_q <<< 1) - ONE;
    aux_d.vp = (g_a_q <<< 1) + ONE;
    aux_d.am = round_frac(p_xsm_q);
    aux_d.ap = round_frac(p_xsp_q);
    aux_d.bm = round_frac(p_gtm_q);
    aux_d.bp = round_frac(p_gtp_q);
    aux_d.c  = -round_frac(p_smsp_q);
    aux_d.d  = -round_frac(p_tmtp_q);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= point_i.valid;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      x_a_q    <= x_in;
      g_a_q    <= g_in;
      p_xsm_q  <= p_xsm_d;
      p_xsp_q  <= p_xsp_d;
      p_gtm_q  <= p_gtm_d;
      p_gtp_q  <= p_gtp_d;
      p_smsp_q <= p_smsp_d;
      p_tmtp_q <= p_tmtp_d;
    end
    if (b_ready) begin
      aux_q <= aux_d;
    end
  end

endmodule

### rtl/qesf_seq.sv
// ----------------------------------------------------------------------------
// qesf_seq
// Node sequencer: steps through the nodes of one point, one per cycle while
// adv_i is high, and selects the operands of the three product terms per node.
// ----------------------------------------------------------------------------
module qesf_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                nine_node_mode_i,
  input  logic                aux_valid_i,
  input  qesf_pkg::aux_t      aux_i,
  output logic                aux_take_o,
  input  logic                adv_i,
  output qesf_pkg::node_op_t  node_op_o
);
  import qesf_pkg::*;

  typedef enum logic [4:0] {
    OPD_X, OPD_G, OPD_ONE,
    OPD_SM, OPD_SP, OPD_TM, OPD_TP,
    OPD_UM, OPD_UP, OPD_VM, OPD_VP,
    OPD_AM, OPD_AP, OPD_BM, OPD_BP,
    OPD_C, OPD_D
  } operand_e;

  typedef struct packed {
    operand_e p;
    operand_e q;
    logic     neg;
    shift_e   sh;
  } term_t;

  function automatic term_t mk(operand_e p, operand_e q, logic neg, shift_e sh);
    term_t t;
    t.p   = p;
    t.q   = q;
    t.neg = neg;
    t.sh  = sh;
    return t;
  endfunction

  // Shape value terms
  function automatic term_t shape_term(logic nine, logic [IDX_W-1:0] k);
    term_t t;
    t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
    if (nine) begin
      case (k)
        4'd0:    t = mk(OPD_AM, OPD_BM, 1'b0, SH_P2);
        4'd1:    t = mk(OPD_AP, OPD_BM, 1'b0, SH_P2);
        4'd2:    t = mk(OPD_AP, OPD_BP, 1'b0, SH_P2);
        4'd3:    t = mk(OPD_AM, OPD_BP, 1'b0, SH_P2);
        4'd4:    t = mk(OPD_BM, OPD_C,  1'b0, SH_P1);
        4'd5:    t = mk(OPD_AP, OPD_D,  1'b0, SH_P1);
        4'd6:    t = mk(OPD_BP, OPD_C,  1'b0, SH_P1);
        4'd7:    t = mk(OPD_AM, OPD_D,  1'b0, SH_P1);
        4'd8:    t = mk(OPD_C,  OPD_D,  1'b0, SH_0);
        default: t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
      endcase
    end else begin
      case (k)
        4'd0:    t = mk(OPD_SM, OPD_TM, 1'b0, SH_P2);
        4'd1:    t = mk(OPD_SP, OPD_TM, 1'b1, SH_P2);
        4'd2:    t = mk(OPD_SP, OPD_TP, 1'b0, SH_P2);
        4'd3:    t = mk(OPD_SM, OPD_TP, 1'b1, SH_P2);
        default: t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
      endcase
    end
    return t;
  endfunction

  // d/dxi terms
  function automatic term_t dxi_term(logic nine, logic [IDX_W-1:0] k);
    term_t t;
    t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
    if (nine) begin
      case (k)
        4'd0:    t = mk(OPD_BM, OPD_UM, 1'b0, SH_P2);
        4'd1:    t = mk(OPD_BM, OPD_UP, 1'b0, SH_P2);
        4'd2:    t = mk(OPD_BP, OPD_UP, 1'b0, SH_P2);
        4'd3:    t = mk(OPD_BP, OPD_UM, 1'b0, SH_P2);
        4'd4:    t = mk(OPD_X,  OPD_BM, 1'b1, SH_0);
        4'd5:    t = mk(OPD_D,  OPD_UP, 1'b0, SH_P1);
        4'd6:    t = mk(OPD_X,  OPD_BP, 1'b1, SH_0);
        4'd7:    t = mk(OPD_D,  OPD_UM, 1'b0, SH_P1);
        4'd8:    t = mk(OPD_X,  OPD_D,  1'b1, SH_M1);
        default: t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
      endcase
    end else begin
      case (k)
        4'd0:    t = mk(OPD_TM, OPD_ONE, 1'b0, SH_P2);
        4'd1:    t = mk(OPD_TM, OPD_ONE, 1'b1, SH_P2);
        4'd2:    t = mk(OPD_TP, OPD_ONE, 1'b0, SH_P2);
        4'd3:    t = mk(OPD_TP, OPD_ONE, 1'b1, SH_P2);
        default: t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
      endcase
    end
    return t;
  endfunction

  // d/dgamma terms
  function automatic term_t dgam_term(logic nine, logic [IDX_W-1:0] k);
    term_t t;
    t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
    if (nine) begin
      case (k)
        4'd0:    t = mk(OPD_AM, OPD_VM, 1'b0, SH_P2);
        4'd1:    t = mk(OPD_AP, OPD_VM, 1'b0, SH_P2);
        4'd2:    t = mk(OPD_AP, OPD_VP, 1'b0, SH_P2);
        4'd3:    t = mk(OPD_AM, OPD_VP, 1'b0, SH_P2);
        4'd4:    t = mk(OPD_C,  OPD_VM, 1'b0, SH_P1);
        4'd5:    t = mk(OPD_G,  OPD_AP, 1'b1, SH_0);
        4'd6:    t = mk(OPD_C,  OPD_VP, 1'b0, SH_P1);
        4'd7:    t = mk(OPD_G,  OPD_AM, 1'b1, SH_0);
        4'd8:    t = mk(OPD_G,  OPD_C,  1'b1, SH_M1);
        default: t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
      endcase
    end else begin
      case (k)
        4'd0:    t = mk(OPD_SM, OPD_ONE, 1'b0, SH_P2);
        4'd1:    t = mk(OPD_SP, OPD_ONE, 1'b1, SH_P2);
        4'd2:    t = mk(OPD_SP, OPD_ONE, 1'b0, SH_P2);
        4'd3:    t = mk(OPD_SM, OPD_ONE, 1'b1, SH_P2);
        default: t = mk(OPD_ONE, OPD_ONE, 1'b0, SH_P2);
      endcase
    end
    return t;
  endfunction

  function automatic logic signed [OP_W-1:0] pick(operand_e s, aux_t a);
    logic signed [OP_W-1:0] v;
    case (s)
      OPD_X:   v = a.x;
      OPD_G:   v = a.g;
      OPD_ONE: v = ONE;
      OPD_SM:  v = a.sm;
      OPD_SP:  v = a.sp;
      OPD_TM:  v = a.tm;
      OPD_TP:  v = a.tp;
      OPD_UM:  v = a.um;
      OPD_UP:  v = a.up;
      OPD_VM:  v = a.vm;
      OPD_VP:  v = a.vp;
      OPD_AM:  v = a.am;
      OPD_AP:  v = a.ap;
      OPD_BM:  v = a.bm;
      OPD_BP:  v = a.bp;
      OPD_C:   v = a.c;
      OPD_D:   v = a.d;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Operands to sign-magnitude, sign folded with the term's own negation
  function automatic factor_t to_factor(term_t t, aux_t a);
    logic signed [OP_W-1:0] p, q;
    factor_t f;
    p       = pick(t.p, a);
    q       = pick(t.q, a);
    f.p_mag = p[OP_W-1] ? OP_W'(-p) : OP_W'(p);
    f.q_mag = q[OP_W-1] ? OP_W'(-q) : OP_W'(q);
    f.neg   = p[OP_W-1] ^ q[OP_W-1] ^ t.neg;
    f.sh    = t.sh;
    return f;
  endfunction

  logic             busy_q, mode_q;
  logic [IDX_W-1:0] idx_q;
  aux_t             aux_q;
  logic [IDX_W-1:0] last_idx;
  logic             at_last, issue, take;
  node_op_t         op_d, op_q;

  // Sequencing control
  assign last_idx   = mode_q ? LAST_Q9 : LAST_Q4;
  assign at_last    = (idx_q == last_idx);
  assign issue      = busy_q && adv_i;
  assign take       = aux_valid_i && (!busy_q || (issue && at_last));
  assign aux_take_o = take;
  assign node_op_o  = op_q;

  // Operand selection for the current node
  always_comb begin
    op_d.valid = issue;
    op_d.idx   = idx_q;
    op_d.last  = at_last;
    op_d.shape = to_factor(shape_term(mode_q, idx_q), aux_q);
    op_d.dxi   = to_factor(dxi_term(mode_q, idx_q), aux_q);
    op_d.dgam  = to_factor(dgam_term(mode_q, idx_q), aux_q);
  end

  // Node counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      mode_q <= 1'b0;
    end else if (take) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      mode_q <= nine_node_mode_i;
    end else if (issue) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // Point terms held while its nodes are issued
  always_ff @(posedge clk_i) begin
    if (take) aux_q <= aux_i;
  end

  // Operand register, first stage of the node pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else if (adv_i) begin
      op_q <= op_d;
    end
  end

  // Checks
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= last_idx))
    else $error("node counter beyond last node");

  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (busy_q && idx_q == '0))
    else $error("new point did not start at node zero");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q.valid && op_q.last) |-> (op_q.idx == LAST_Q4 || op_q.idx == LAST_Q9))
    else $error("last flag on a node that is not final");

  a_idle_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (aux_valid_i && !busy_q) |-> take)
    else $error("idle sequencer left a point waiting");

endmodule

### rtl/qesf_eval.sv
// ----------------------------------------------------------------------------
// qesf_eval
// Node evaluation pipeline: multiply, round, saturate into the output
// register. The whole pipeline advances whenever the output can move.
// ----------------------------------------------------------------------------
module qesf_eval (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qesf_pkg::node_op_t  node_op_i,
  output logic                adv_o,
  qesf_node_if.source         node_o
);
  import qesf_pkg::*;

  typedef struct packed {
    logic [PROD_W-1:0] mag;
    logic              neg;
    shift_e            sh;
  } prod_t;

  typedef struct packed {
    logic [RND_W-1:0] mag;
    logic             neg;
  } rnd_t;

  localparam logic [RND_W-1:0] POS_LIM = RND_W'((64'd1 << (RES_W - 1)) - 64'd1);
  localparam logic [RND_W-1:0] NEG_LIM = RND_W'(64'd1 << (RES_W - 1));

  function automatic prod_t multiply(factor_t f);
    prod_t r;
    r.mag = PROD_W'(f.p_mag) * PROD_W'(f.q_mag);
    r.neg = f.neg;
    r.sh  = f.sh;
    return r;
  endfunction

  // Magnitude rounding, ties away from zero
  function automatic rnd_t round_mag(prod_t p);
    logic [SUM_W-1:0] sum;
    int unsigned      sa;
    rnd_t             r;
    case (p.sh)
      SH_M1:   sa = FRAC_BITS - 1;
      SH_0:    sa = FRAC_BITS;
      SH_P1:   sa = FRAC_BITS + 1;
      SH_P2:   sa = FRAC_BITS + 2;
      default: sa = FRAC_BITS;
    endcase
    sum   = {1'b0, p.mag} + (SUM_W'(1) << (sa - 1));
    r.mag = RND_W'(sum >> sa);
    r.neg = p.neg;
    return r;
  endfunction

  function automatic logic [RES_W-1:0] saturate(rnd_t r);
    logic [RES_W-1:0] v;
    if (!r.neg) begin
      v = (r.mag > POS_LIM) ? RES_W'(POS_LIM) : RES_W'(r.mag);
    end else begin
      v = (r.mag > NEG_LIM) ? RES_W'(NEG_LIM) : RES_W'(RND_W'(0) - r.mag);
    end
    return v;
  endfunction

  logic             v1_q, v2_q, out_valid_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx_out_q;
  logic             last1_q, last2_q, last_out_q;
  prod_t            pn_q, px_q, pg_q;
  rnd_t             rn_q, rx_q, rg_q;
  logic [RES_W-1:0] shape_q, dxi_q, dgam_q;

  // Global advance: the output register is free or being emptied
  assign adv_o = !out_valid_q || node_o.ready;

  assign node_o.valid       = out_valid_q;
  assign node_o.node_index  = idx_out_q;
  assign node_o.shape_value = shape_q;
  assign node_o.deriv_xi    = dxi_q;
  assign node_o.deriv_gamma = dgam_q;
  assign node_o.last_node   = last_out_q;

  // Valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      v1_q        <= node_op_i.valid;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // Multiply, round, saturate
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      idx1_q     <= node_op_i.idx;
      last1_q    <= node_op_i.last;
      pn_q       <= multiply(node_op_i.shape);
      px_q       <= multiply(node_op_i.dxi);
      pg_q       <= multiply(node_op_i.dgam);
      idx2_q     <= idx1_q;
      last2_q    <= last1_q;
      rn_q       <= round_mag(pn_q);
      rx_q       <= round_mag(px_q);
      rg_q       <= round_mag(pg_q);
      idx_out_q  <= idx2_q;
      last_out_q <= last2_q;
      shape_q    <= saturate(rn_q);
      dxi_q      <= saturate(rx_q);
      dgam_q     <= saturate(rg_q);
    end
  end

endmodule

### rtl/quad_element_shape_functions.sv
// ----------------------------------------------------------------------------
// quad_element_shape_functions
// Bilinear (4-node) and biquadratic (9-node) quadrilateral shape functions and
// their derivatives at a reference point, one node result per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   point_i : one transaction per reference point (coord_xi, coord_gamma),
//             Q2.14 signed.
//   node_o  : 4 or 9 transactions per point, nodes in order, last_node set
//             on the final one. Values Q4.14 signed, rounded and saturated.
//   cfg_we_i/cfg_wdata_i : element type, 1 selects nine nodes. Write only
//             while no point is in flight; reset selects four nodes.
// Path to the first node result: the accepting edge loads the first front-end
//   stage; then second front-end stage, sequencer handoff, operand, multiply,
//   round, saturate/output register.
// Throughput: one node result per cycle while node_o is not stalled, set by
//   the node sequencer; the next point's terms are prepared in the front end
//   meanwhile and follow with no gap.
// Reset clears all valid bits and the element type register.
// A stall on node_o freezes the whole node pipeline; point_i keeps
//   accepting until the two front-end buffers are full.
// ----------------------------------------------------------------------------
module quad_element_shape_functions (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  qesf_point_if.sink    point_i,
  qesf_node_if.source   node_o
);
  import qesf_pkg::*;

  logic     nine_node_mode_q;
  logic     aux_valid, aux_take, adv;
  aux_t     aux;
  node_op_t node_op;

  // Element type register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nine_node_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      nine_node_mode_q <= cfg_wdata_i;
    end
  end

  qesf_aux u_aux (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_i     (point_i),
    .aux_valid_o (aux_valid),
    .aux_o       (aux),
    .aux_take_i  (aux_take)
  );

  qesf_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .nine_node_mode_i (nine_node_mode_q),
    .aux_valid_i      (aux_valid),
    .aux_i            (aux),
    .aux_take_o       (aux_take),
    .adv_i            (adv),
    .node_op_o        (node_op)
  );

  qesf_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .node_op_i (node_op),
    .adv_o     (adv),
    .node_o    (node_o)
  );

endmodule

### bench/qesf_shape_monitor.sv
// ----------------------------------------------------------------------------
// qesf_shape_monitor
// Watches the point and node channels of the shape function block, works out
// the 4 or 9 node results of every accepted point and compares each node
// transaction with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module qesf_shape_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  qesf_point_if       point_i,
  qesf_node_if        node_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned nodes_checked_o
);
  import qesf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RES_MAX = (longint'(1) <<< (RES_W - 1)) - 1;
  localparam longint RES_MIN = -(longint'(1) <<< (RES_W - 1));

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [RES_W-1:0] shape;
    logic signed [RES_W-1:0] dxi;
    logic signed [RES_W-1:0] dgam;
    logic                    last;
  } node_result_t;

  node_result_t expected_nodes[$];
  logic         nine_node_mode;
  int unsigned  fail_count;
  int unsigned  nodes_checked;
  int unsigned  reported;

  // Round v / 2^sh to nearest, ties away from zero
  function automatic longint round_near(longint v, int unsigned sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic logic signed [RES_W-1:0] clamp_res(longint v);
    if (v > RES_MAX) v = RES_MAX;
    if (v < RES_MIN) v = RES_MIN;
    return v[RES_W-1:0];
  endfunction

  // Shape values and derivatives of every node at one point
  function automatic void predict_nodes(logic signed [COORD_W-1:0] xi_q,
                                        logic signed [COORD_W-1:0] ga_q,
                                        logic nine);
    longint       x, g, one, sm, sp, tm, tp;
    longint       am, ap, bm, bp, c, d, um, up, vm, vp;
    longint       nv[9], dx[9], dg[9];
    int unsigned  f;
    int           n;
    node_result_t r;
    f   = FRAC_BITS;
    one = longint'(1) <<< FRAC_BITS;
    x   = longint'(xi_q);
    g   = longint'(ga_q);
    sm  = x - one;
    sp  = x + one;
    tm  = g - one;
    tp  = g + one;
    if (!nine) begin
      n = NODES_Q4;
      nv[0] = round_near(sm * tm, f + 2);
      nv[1] = round_near(-(sp * tm), f + 2);
      nv[2] = round_near(sp * tp, f + 2);
      nv[3] = round_near(-(sm * tp), f + 2);
      dx[0] = round_near(tm, 2);
      dx[1] = round_near(-tm, 2);
      dx[2] = round_near(tp, 2);
      dx[3] = round_near(-tp, 2);
      dg[0] = round_near(sm, 2);
      dg[1] = round_near(-sp, 2);
      dg[2] = round_near(sp, 2);
      dg[3] = round_near(-sm, 2);
    end else begin
      n  = NODES_Q9;
      am = round_near(x * sm, f);
      ap = round_near(x * sp, f);
      bm = round_near(g * tm, f);
      bp = round_near(g * tp, f);
      c  = round_near(-(sm * sp), f);
      d  = round_near(-(tm * tp), f);
      um = 2 * x - one;
      up = 2 * x + one;
      vm = 2 * g - one;
      vp = 2 * g + one;
      // corners, midsides, centre
      nv[0] = round_near(am * bm, f + 2);
      nv[1] = round_near(ap * bm, f + 2);
      nv[2] = round_near(ap * bp, f + 2);
      nv[3] = round_near(am * bp, f + 2);
      nv[4] = round_near(bm * c, f + 1);
      nv[5] = round_near(ap * d, f + 1);
      nv[6] = round_near(bp * c, f + 1);
      nv[7] = round_near(am * d, f + 1);
      nv[8] = round_near(c * d, f);
      dx[0] = round_near(bm * um, f + 2);
      dx[1] = round_near(bm * up, f + 2);
      dx[2] = round_near(bp * up, f + 2);
      dx[3] = round_near(bp * um, f + 2);
      dx[4] = round_near(-(x * bm), f);
      dx[5] = round_near(d * up, f + 1);
      dx[6] = round_near(-(x * bp), f);
      dx[7] = round_near(d * um, f + 1);
      dx[8] = round_near(-(x * d), f - 1);
      dg[0] = round_near(am * vm, f + 2);
      dg[1] = round_near(ap * vm, f + 2);
      dg[2] = round_near(ap * vp, f + 2);
      dg[3] = round_near(am * vp, f + 2);
      dg[4] = round_near(c * vm, f + 1);
      dg[5] = round_near(-(g * ap), f);
      dg[6] = round_near(c * vp, f + 1);
      dg[7] = round_near(-(g * am), f);
      dg[8] = round_near(-(g * c), f - 1);
    end
    for (int k = 0; k < n; k++) begin
      r.idx   = IDX_W'(k);
      r.shape = clamp_res(nv[k]);
      r.dxi   = clamp_res(dx[k]);
      r.dgam  = clamp_res(dg[k]);
      r.last  = (k == n - 1);
      expected_nodes.push_back(r);
    end
  endfunction

  // Own copy of the element type register
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nine_node_mode <= 1'b0;
    end else if (cfg_we_i) begin
      nine_node_mode <= cfg_wdata_i;
    end
  end

  // Predict on point transactions, compare on node transactions
  always @(posedge clk_i or negedge rst_ni) begin
    node_result_t want;
    if (!rst_ni) begin
      expected_nodes.delete();
      fail_count    = 0;
      nodes_checked = 0;
      reported      = 0;
    end else begin
      if (point_i.valid && point_i.ready) begin
        predict_nodes(point_i.coord_xi, point_i.coord_gamma, nine_node_mode);
      end
      if (node_i.valid && node_i.ready) begin
        nodes_checked++;
        if (expected_nodes.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: node result idx %0d with no point outstanding",
                     $realtime, node_i.node_index);
          end
        end else begin
          want = expected_nodes.pop_front();
          if (node_i.node_index !== want.idx || node_i.shape_value !== want.shape ||
              node_i.deriv_xi !== want.dxi || node_i.deriv_gamma !== want.dgam ||
              node_i.last_node !== want.last) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: node mismatch, expected idx %0d N %0d dxi %0d dgam %0d last %0d",
                       $realtime, want.idx, want.shape, want.dxi, want.dgam, want.last);
              $display("%0t:                got      idx %0d N %0d dxi %0d dgam %0d last %0d",
                       $realtime, node_i.node_index, node_i.shape_value, node_i.deriv_xi,
                       node_i.deriv_gamma, node_i.last_node);
            end
          end
        end
      end
    end
    fail_count_o    <= fail_count;
    pending_o       <= expected_nodes.size();
    nodes_checked_o <= nodes_checked;
  end

endmodule

### bench/tb_quad_element_shape_functions.sv
// ----------------------------------------------------------------------------
// tb_quad_element_shape_functions
// Drives reference points through the shape function block in both element
// types, with random gaps on the point side and random stalls on the node
// side; the monitor beside the block checks every node result.
// ----------------------------------------------------------------------------
module tb_quad_element_shape_functions;
  import qesf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int          N_DIRECTED  = 12;

  typedef logic signed [COORD_W-1:0] coord_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  bit          idling_on;
  int unsigned points_sent;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned pending_nodes;
  int unsigned nodes_checked;

  // Corners, centre, an interior point, far outside the element, rounding ties
  int dir_xi[N_DIRECTED] = '{-16384, 16384, 16384, -16384, 0, 8192,
                             -32768, 32767, -32768, 1, 2, -8193};
  int dir_ga[N_DIRECTED] = '{-16384, -16384, 16384, 16384, 0, -8192,
                             -32768, 32767, 32767, -1, -6, 8191};

  qesf_point_if point_ch ();
  qesf_node_if  node_ch ();

  quad_element_shape_functions dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .point_i     (point_ch),
    .node_o      (node_ch)
  );

  qesf_shape_monitor u_shape_mon (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .point_i         (point_ch),
    .node_i          (node_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending_nodes),
    .nodes_checked_o (nodes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly inside the element, some anywhere in the field, some extremes
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom());
      1: begin
        case ($urandom_range(0, 6))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd16384;
          3: return 16'sd16384;
          4: return 16'sd1;
          5: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return coord_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic send_point(coord_t xi, coord_t ga);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      point_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    point_ch.valid       <= 1'b1;
    point_ch.coord_xi    <= xi;
    point_ch.coord_gamma <= ga;
    do @(posedge clk); while (!point_ch.ready);
    points_sent++;
  endtask

  task automatic drain_nodes();
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_nodes != 0) @(posedge clk);
  endtask

  // Element type change, only with nothing in flight
  task automatic write_mode(logic nine);
    drain_nodes();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= nine;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_point(pick_coord(), pick_coord());
    end
  endtask

  task automatic run_directed();
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_point(coord_t'(dir_xi[i]), coord_t'(dir_ga[i]));
    end
  endtask

  // Node side back-pressure
  initial begin
    node_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (idling_on && $urandom_range(0, 3) == 0) begin
        node_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        node_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (point_ch.valid && point_ch.ready) || (node_ch.valid && node_ch.ready)
        || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= 1'b0;
    point_ch.valid       <= 1'b0;
    point_ch.coord_xi    <= '0;
    point_ch.coord_gamma <= '0;
    points_sent          = 0;
    idling_on            = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // four-node element straight out of reset, then nine-node
    run_directed();
    write_mode(1'b1);
    run_directed();
    run_random(40);
    write_mode(1'b0);
    run_random(40);
    write_mode(1'b1);
    run_random(35);
    write_mode(1'b0);

    // closing stretch at full rate on both sides
    idling_on = 1'b0;
    run_random(31);
    drain_nodes();
    repeat (20) @(posedge clk);

    $display("Run covered %0d points (%0d directed) across both element types,",
             points_sent, 2 * N_DIRECTED);
    $display("with %0d node results compared against the predicted values.",
             nodes_checked);
    if (fail_count == 0 && pending_nodes == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
